@@ rtl/rrs_pkg.sv @@
package rrs_pkg;

  // Field widths fixed by the item formats.
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int PIDX_W  = 4;
  localparam int QUANT_W = 16;

  // Configuration register map (word index) and reset value.
  localparam logic REG_QUANTUM = 1'b0;
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd4;

  // Operation codes of an input word.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // One input word.
  typedef struct packed {
    logic               operation;
    logic [BURST_W-1:0] burst;
  } job_t;

  // One result word.
  typedef struct packed {
    logic               slice_valid;
    logic [PIDX_W-1:0]  proc_index;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic [TIME_W-1:0]  slice_wait;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  proc_wait_total;
    logic [TIME_W-1:0]  total_wait;
    logic               all_done;
  } slice_t;

  // One process entry of the table.
  typedef struct packed {
    logic [BURST_W-1:0] rem;
    logic [TIME_W-1:0]  last_end;
    logic [TIME_W-1:0]  acc;
  } entry_t;

endpackage

@@ rtl/rrs_if.sv @@
interface rrs_job_if;
  import rrs_pkg::*;

  logic valid;
  logic ready;
  job_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrs_slice_if;
  import rrs_pkg::*;

  logic   valid;
  logic   ready;
  slice_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rrs_table.sv @@
module rrs_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  rrs_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output rrs_pkg::entry_t rd_data
);
  import rrs_pkg::*;

  entry_t mem [DEPTH];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/rrs_cfg.sv @@
module rrs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [rrs_pkg::QUANT_W-1:0] quantum
);
  import rrs_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_QUANTUM);

  // Quantum register, written in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (wr_hit) begin
      quantum <= pwdata[QUANT_W-1:0];
    end
  end

  // Read back; addresses past the register map read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_QUANTUM) begin
      prdata = {{(32-QUANT_W){1'b0}}, quantum};
    end
  end

endmodule

@@ rtl/round_robin_slice_scheduler.sv @@
// Load word: gives no result; a load may follow at once.
// Step word: P entries are probed, one per cycle, until one with burst left is
// found (1 <= P <= loaded count); the slice is worked out in the calc state and
// registered in the write state, after which the next word can be taken.
// A step with nothing left registers its result at the edge that takes it.
// Reset clears counters, pointer, time and wait sum and sets the quantum to 4.
module round_robin_slice_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rrs_job_if.sink     job,
  rrs_slice_if.source slice,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rrs_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]         state;
  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   done_count;
  logic [IDX_W-1:0]   next_pointer;
  logic [TIME_W-1:0]  current_time;
  logic [TIME_W-1:0]  wait_sum;
  logic [IDX_W-1:0]   scan_idx;
  logic [CNT_W-1:0]   probe_count;
  entry_t             hold;
  logic [TIME_W-1:0]  calc_wait;
  logic [TIME_W-1:0]  calc_end;
  logic [BURST_W-1:0] calc_rem;
  logic               out_valid;
  slice_t             out_data;

  logic [QUANT_W-1:0] quantum;
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_waddr;
  entry_t             tbl_wdata;
  logic [IDX_W-1:0]   tbl_raddr;
  entry_t             tbl_rdata;

  logic               accept;
  logic               is_load;
  logic [IDX_W-1:0]   start_ptr;
  logic [IDX_W-1:0]   scan_next;
  logic               scan_hit;
  logic [CNT_W-1:0]   probe_next;
  logic [BURST_W-1:0] q_eff;
  logic [BURST_W-1:0] run_len;
  logic [TIME_W-1:0]  acc_next;
  logic [TIME_W-1:0]  wait_sum_next;
  logic [CNT_W-1:0]   done_next;
  logic [IDX_W-1:0]   ptr_after;
  slice_t             idle_word;

  rrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .quantum (quantum)
  );

  rrs_table #(
    .DEPTH (MAX_PROCS),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  // Handshake: one word in flight, and the result register must be free.
  assign job.ready   = (state == S_IDLE) && (!out_valid || slice.ready);
  assign accept      = job.valid && job.ready;
  assign is_load     = (job.data.operation == OP_LOAD);
  assign slice.valid = out_valid;
  assign slice.data  = out_data;

  // Cyclic scan pointers.
  always_comb begin
    start_ptr = (CNT_W'(next_pointer) < loaded_count) ? next_pointer : '0;
    scan_next = ((CNT_W'(scan_idx) + CNT_W'(1)) >= loaded_count) ? '0
              : IDX_W'(scan_idx + IDX_W'(1));
    ptr_after = scan_next;
    scan_hit  = (tbl_rdata.rem != '0);
    probe_next = probe_count + CNT_W'(1);
  end

  // Table address selection.
  always_comb begin
    case (state)
      S_IDLE:  tbl_raddr = start_ptr;
      S_SCAN:  tbl_raddr = scan_next;
      default: tbl_raddr = scan_idx;
    endcase
    tbl_we    = 1'b0;
    tbl_waddr = scan_idx;
    tbl_wdata = '{rem: calc_rem, last_end: calc_end, acc: acc_next};
    if (state == S_WRITE) begin
      tbl_we = 1'b1;
    end else if (accept && is_load && (loaded_count < CNT_W'(MAX_PROCS))) begin
      tbl_we    = 1'b1;
      tbl_waddr = loaded_count[IDX_W-1:0];
      tbl_wdata = '{rem: job.data.burst, last_end: '0, acc: '0};
    end
  end

  // Slice length and timing arithmetic.
  always_comb begin
    q_eff         = (quantum == '0) ? BURST_W'(1) : quantum;
    run_len       = (hold.rem < q_eff) ? hold.rem : q_eff;
    acc_next      = hold.acc + calc_wait;
    wait_sum_next = wait_sum + calc_wait;
    done_next     = done_count + CNT_W'(calc_rem == '0);
  end

  // Result for a step that finds nothing to run.
  always_comb begin
    idle_word             = '0;
    idle_word.start_time  = current_time;
    idle_word.end_time    = current_time;
    idle_word.total_wait  = wait_sum;
    idle_word.all_done    = 1'b1;
  end

  // Control sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      done_count   <= '0;
      next_pointer <= '0;
      current_time <= '0;
      wait_sum     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && slice.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (loaded_count < CNT_W'(MAX_PROCS)) begin
                loaded_count <= loaded_count + CNT_W'(1);
                if (job.data.burst == '0) begin
                  done_count <= done_count + CNT_W'(1);
                end
              end
            end else if (done_count < loaded_count) begin
              state <= S_SCAN;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            state <= S_CALC;
          end else if (probe_next >= loaded_count) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        S_CALC: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          state        <= S_IDLE;
          out_valid    <= 1'b1;
          current_time <= calc_end;
          wait_sum     <= wait_sum_next;
          done_count   <= done_next;
          next_pointer <= ptr_after;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan position, held entry, slice arithmetic and result word.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        scan_idx    <= start_ptr;
        probe_count <= '0;
        // Only a taken step replaces the result word, so a waiting one is kept.
        if (accept && !is_load) begin
          out_data <= idle_word;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          hold <= tbl_rdata;
        end else begin
          scan_idx    <= scan_next;
          probe_count <= probe_next;
          out_data    <= idle_word;
        end
      end
      S_CALC: begin
        calc_wait <= current_time - hold.last_end;
        calc_end  <= current_time + TIME_W'(run_len);
        calc_rem  <= hold.rem - run_len;
      end
      S_WRITE: begin
        out_data.slice_valid     <= 1'b1;
        out_data.proc_index      <= PIDX_W'(scan_idx);
        out_data.start_time      <= current_time;
        out_data.end_time        <= calc_end;
        out_data.slice_wait      <= calc_wait;
        out_data.remaining       <= calc_rem;
        out_data.proc_wait_total <= acc_next;
        out_data.total_wait      <= wait_sum_next;
        out_data.all_done        <= (done_next >= loaded_count);
      end
      default: begin
        probe_count <= '0;
      end
    endcase
  end

endmodule
